FILE: rtl/core/teq_pkg.sv
// Shared types and constants for the timed event queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package teq_pkg;

  localparam int TEQ_DEPTH   = 8;
  localparam int ACTION_W    = 2;
  localparam int CODE_W      = 8;
  localparam int PAYLOAD_W   = 8;
  localparam int DELAY_W     = 16;
  localparam int ELAPSED_W   = 8;
  localparam int STATUS_W    = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED     = 3'd0,
    STS_UPDATED   = 3'd1,
    STS_FULL      = 3'd2,
    STS_INVALID   = 3'd3,
    STS_CANCELLED = 3'd4,
    STS_NOTFOUND  = 3'd5,
    STS_EXPIRED   = 3'd6,
    STS_DONE      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;   // capture the input beat
    logic exec;   // run add, cancel or reject and write one result
    logic decay;  // subtract elapsed from every delay
    logic scan;   // emit the first expired entry, or the done result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic item_tick;
    logic zero_found;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/teq_in_if.sv
// Input channel of the timed event queue: valid/ready plus request fields.
// Depends on teq_pkg for field widths.
interface teq_in_if import teq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [CODE_W-1:0]    event_code;
  logic [PAYLOAD_W-1:0] payload;
  logic [DELAY_W-1:0]   delay;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, action, event_code, payload, delay, elapsed, input ready);
  modport sink   (input valid, action, event_code, payload, delay, elapsed, output ready);
endinterface

FILE: rtl/core/teq_out_if.sv
// Result channel of the timed event queue: valid/ready plus result fields.
// Depends on teq_pkg for field widths.
interface teq_out_if import teq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CODE_W-1:0]    fired_code;
  logic [PAYLOAD_W-1:0] fired_payload;
  logic                 last;

  modport source (output valid, status, fired_code, fired_payload, last, input ready);
  modport sink   (input valid, status, fired_code, fired_payload, last, output ready);
endinterface

FILE: rtl/core/teq_ctrl.sv
// Sequencing state machine of the timed event queue.
// Depends on teq_pkg for state, command and status types.
module teq_ctrl import teq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.item_tick) begin
          cmd.decay = 1'b1;
          state_nxt = S_SCAN;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // one expired entry per beat; the done beat ends the tick
        if (sts.out_free) begin
          cmd.scan = 1'b1;
          if (!sts.zero_found) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/teq_dpath.sv
// Event table, item register and result register of the timed event queue.
// Depends on teq_pkg and teq_out_if; driven by commands from teq_ctrl.
module teq_dpath import teq_pkg::*; #(
  parameter int DEPTH = TEQ_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [CODE_W-1:0]    in_event_code,
  input  logic [PAYLOAD_W-1:0] in_payload,
  input  logic [DELAY_W-1:0]   in_delay,
  input  logic [ELAPSED_W-1:0] in_elapsed,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  teq_out_if.source            out_if
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  // event table; codes at and above count_r are always zero
  logic [CODE_W-1:0]    code_r [DEPTH];
  logic [PAYLOAD_W-1:0] pay_r  [DEPTH];
  logic [DELAY_W-1:0]   dly_r  [DEPTH];
  logic [CODE_W-1:0]    code_nxt [DEPTH];
  logic [PAYLOAD_W-1:0] pay_nxt  [DEPTH];
  logic [DELAY_W-1:0]   dly_nxt  [DEPTH];
  logic [CntW-1:0]      count_r, count_nxt;

  // captured request
  action_t              act_r;
  logic [CODE_W-1:0]    ecode_r;
  logic [PAYLOAD_W-1:0] epay_r;
  logic [DELAY_W-1:0]   edly_r;
  logic [ELAPSED_W-1:0] el_r;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [CODE_W-1:0]    fcode_r, fcode_nxt;
  logic [PAYLOAD_W-1:0] fpay_r, fpay_nxt;
  logic                 last_r, last_nxt;

  logic            match_found, zero_found;
  logic [IdxW-1:0] match_idx, zero_idx, rm_idx;
  logic            is_add, is_cancel, code_ok, full;
  logic            do_update, do_append, do_cancel, do_expire, remove_en, out_free;

  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    zero_found  = 1'b0;
    zero_idx    = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((CntW'(i) < count_r) && (code_r[i] == ecode_r)) begin
        match_found = 1'b1;
        match_idx   = IdxW'(i);
      end
      if ((CntW'(i) < count_r) && (dly_r[i] == '0)) begin
        zero_found = 1'b1;
        zero_idx   = IdxW'(i);
      end
    end
  end

  assign is_add    = (act_r == ACT_ADD);
  assign is_cancel = (act_r == ACT_CANCEL);
  assign code_ok   = (ecode_r != '0);
  assign full      = (count_r == CntW'(DEPTH));
  assign out_free  = !out_valid_r || out_if.ready;

  assign do_update = cmd.exec && is_add && code_ok && match_found;
  assign do_append = cmd.exec && is_add && code_ok && !match_found && !full;
  assign do_cancel = cmd.exec && is_cancel && code_ok && match_found;
  assign do_expire = cmd.scan && zero_found;
  assign remove_en = do_cancel || do_expire;
  assign rm_idx    = do_expire ? zero_idx : match_idx;

  for (genvar j = 0; j < DEPTH; j++) begin : g_entry
    logic [CODE_W-1:0]    up_code;
    logic [PAYLOAD_W-1:0] up_pay;
    logic [DELAY_W-1:0]   up_dly;

    if (j < DEPTH - 1) begin : g_up
      assign up_code = code_r[j+1];
      assign up_pay  = pay_r[j+1];
      assign up_dly  = dly_r[j+1];
    end else begin : g_top
      assign up_code = '0;
      assign up_pay  = pay_r[j];
      assign up_dly  = dly_r[j];
    end

    always_comb begin
      code_nxt[j] = code_r[j];
      pay_nxt[j]  = pay_r[j];
      dly_nxt[j]  = dly_r[j];
      if (cmd.decay) begin
        // saturate at zero
        if ({{(DELAY_W-ELAPSED_W){1'b0}}, el_r} >= dly_r[j]) begin
          dly_nxt[j] = '0;
        end else begin
          dly_nxt[j] = dly_r[j] - {{(DELAY_W-ELAPSED_W){1'b0}}, el_r};
        end
      end
      if (do_update && (IdxW'(j) == match_idx)) begin
        pay_nxt[j] = epay_r;
        dly_nxt[j] = edly_r;
      end
      if (do_append && (CntW'(j) == count_r)) begin
        code_nxt[j] = ecode_r;
        pay_nxt[j]  = epay_r;
        dly_nxt[j]  = edly_r;
      end
      // close the gap: every entry at or above the removed one takes its upper neighbor
      if (remove_en && (IdxW'(j) >= rm_idx)) begin
        code_nxt[j] = up_code;
        pay_nxt[j]  = up_pay;
        dly_nxt[j]  = up_dly;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_append) begin
      count_nxt = count_r + CntW'(1);
    end else if (remove_en) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    fcode_nxt     = fcode_r;
    fpay_nxt      = fpay_r;
    last_nxt      = last_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      fcode_nxt     = '0;
      fpay_nxt      = '0;
      last_nxt      = 1'b1;
      if (!code_ok || !(is_add || is_cancel)) begin
        status_nxt = STS_INVALID;
      end else if (is_add) begin
        if (match_found) begin
          status_nxt = STS_UPDATED;
        end else if (full) begin
          status_nxt = STS_FULL;
        end else begin
          status_nxt = STS_ADDED;
        end
      end else begin
        status_nxt = match_found ? STS_CANCELLED : STS_NOTFOUND;
      end
    end else if (cmd.scan) begin
      out_valid_nxt = 1'b1;
      if (zero_found) begin
        status_nxt = STS_EXPIRED;
        fcode_nxt  = code_r[zero_idx];
        fpay_nxt   = pay_r[zero_idx];
        last_nxt   = 1'b0;
      end else begin
        status_nxt = STS_DONE;
        fcode_nxt  = '0;
        fpay_nxt   = '0;
        last_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        code_r[i] <= '0;
      end
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        code_r[i] <= code_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      pay_r[i] <= pay_nxt[i];
      dly_r[i] <= dly_nxt[i];
    end
    status_r <= status_nxt;
    fcode_r  <= fcode_nxt;
    fpay_r   <= fpay_nxt;
    last_r   <= last_nxt;
    if (cmd.load) begin
      act_r   <= action_t'(in_action);
      ecode_r <= in_event_code;
      epay_r  <= in_payload;
      edly_r  <= in_delay;
      el_r    <= in_elapsed;
    end
  end

  assign sts.item_tick  = (act_r == ACT_TICK);
  assign sts.zero_found = zero_found;
  assign sts.out_free   = out_free;

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = status_r;
  assign out_if.fired_code    = fcode_r;
  assign out_if.fired_payload = fpay_r;
  assign out_if.last          = last_r;

endmodule

FILE: rtl/core/timed_event_queue_core.sv
// Timed event queue: an ordered table of pending events with add, cancel and tick.
// Usage: each request beat on in_if is one of add (action 0), cancel (1) or tick (2);
// action 3 and event code 0 on add or cancel give one invalid result.
// Add and cancel give one result beat on out_if with last set. A tick lowers every
// delay by elapsed (stopping at zero), then gives one expired beat per entry at zero,
// in table order, and ends with a done beat that carries last.
// Order: an add or cancel request is captured, then its result is written to the
// result register once that is free; a tick that expires k entries first lowers the
// delays, then gives one beat per cycle while out_if.ready is high, k + 1 beats in all.
// A new request is not taken until the previous one has written its last result beat,
// since the controller accepts requests only in its idle state.
// in_if.ready is high only while the controller is idle; a new request is taken
// while the previous result still waits in the output register.
// If out_if.ready is low the result register holds and the sequence pauses.
// Reset (synchronous, rst_n low) empties the table and drops any pending result.
// Depends on teq_pkg, teq_in_if, teq_out_if, teq_ctrl and teq_dpath.
module timed_event_queue_core import teq_pkg::*; #(
  parameter int DEPTH = TEQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  teq_in_if.sink     in_if,
  teq_out_if.source  out_if
);

  cmd_t cmd;
  sts_t sts;
  logic ctl_ready;

  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (ctl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  teq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_if.action),
    .in_event_code (in_if.event_code),
    .in_payload    (in_if.payload),
    .in_delay      (in_if.delay),
    .in_elapsed    (in_if.elapsed),
    .cmd           (cmd),
    .sts           (sts),
    .out_if        (out_if)
  );

  assign in_if.ready = ctl_ready;

endmodule

FILE: tb/timed_event_queue_core_tb.sv
// Self-checking testbench for timed_event_queue_core: add, cancel and tick requests
// against a local model of the event table, with random sender gaps and sink stalls.
// Depends on teq_pkg, teq_in_if, teq_out_if and the core RTL.
module timed_event_queue_core_tb import teq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    status_t              status;
    logic [CODE_W-1:0]    code;
    logic [PAYLOAD_W-1:0] pay;
    logic                 last;
  } result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  teq_in_if  in_ch ();
  teq_out_if out_ch ();

  timed_event_queue_core #(.DEPTH(TEQ_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the event table
  logic [CODE_W-1:0]    tbl_code [TEQ_DEPTH];
  logic [PAYLOAD_W-1:0] tbl_pay  [TEQ_DEPTH];
  logic [DELAY_W-1:0]   tbl_dly  [TEQ_DEPTH];
  int                   tbl_count = 0;

  result_t due_results [$];

  int err_count   = 0;
  int n_req       = 0;
  int n_results   = 0;
  int n_fired     = 0;
  int n_full      = 0;
  int cycle_count = 0;

  // Sender burst and sink stall knobs
  int gap_max    = 0;
  int burst_max  = 1;
  int burst_left = 0;
  int stall_pct  = 0;
  int stall_max  = 1;

  function automatic void push_result(status_t st, logic [CODE_W-1:0] code,
                                      logic [PAYLOAD_W-1:0] pay, logic last);
    result_t r;
    r.status = st;
    r.code   = code;
    r.pay    = pay;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  // Remove one entry and close the gap
  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < tbl_count; i++) begin
      tbl_code[i] = tbl_code[i+1];
      tbl_pay[i]  = tbl_pay[i+1];
      tbl_dly[i]  = tbl_dly[i+1];
    end
    tbl_code[tbl_count-1] = '0;
    tbl_count--;
  endfunction

  function automatic void apply_request(action_t act, logic [CODE_W-1:0] code,
                                        logic [PAYLOAD_W-1:0] pay,
                                        logic [DELAY_W-1:0] dly,
                                        logic [ELAPSED_W-1:0] el);
    int idx;
    int i;
    idx = -1;
    for (i = 0; i < tbl_count; i++)
      if (idx < 0 && tbl_code[i] == code) idx = i;
    case (act)
      ACT_ADD: begin
        if (code == '0) push_result(STS_INVALID, '0, '0, 1'b1);
        else if (idx >= 0) begin
          tbl_pay[idx] = pay;
          tbl_dly[idx] = dly;
          push_result(STS_UPDATED, '0, '0, 1'b1);
        end else if (tbl_count < TEQ_DEPTH) begin
          tbl_code[tbl_count] = code;
          tbl_pay[tbl_count]  = pay;
          tbl_dly[tbl_count]  = dly;
          tbl_count++;
          push_result(STS_ADDED, '0, '0, 1'b1);
        end else begin
          push_result(STS_FULL, '0, '0, 1'b1);
        end
      end
      ACT_CANCEL: begin
        if (code == '0) push_result(STS_INVALID, '0, '0, 1'b1);
        else if (idx >= 0) begin
          drop_entry(idx);
          push_result(STS_CANCELLED, '0, '0, 1'b1);
        end else begin
          push_result(STS_NOTFOUND, '0, '0, 1'b1);
        end
      end
      ACT_TICK: begin
        for (i = 0; i < tbl_count; i++)
          tbl_dly[i] = (el >= tbl_dly[i]) ? '0 : tbl_dly[i] - el;
        // Fire zero-delay entries in table order; hold the index after a removal
        i = 0;
        while (i < tbl_count) begin
          if (tbl_dly[i] == '0) begin
            push_result(STS_EXPIRED, tbl_code[i], tbl_pay[i], 1'b0);
            drop_entry(i);
          end else begin
            i++;
          end
        end
        push_result(STS_DONE, '0, '0, 1'b1);
      end
      default: push_result(STS_INVALID, '0, '0, 1'b1);
    endcase
  endfunction

  // Drive one request beat; entered and left at a falling edge
  task automatic send_req(input action_t act, input logic [CODE_W-1:0] code,
                          input logic [PAYLOAD_W-1:0] pay,
                          input logic [DELAY_W-1:0] dly,
                          input logic [ELAPSED_W-1:0] el);
    if (gap_max > 0 && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(negedge clk);
      burst_left = $urandom_range(burst_max, 1);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.event_code <= code;
    in_ch.payload    <= pay;
    in_ch.delay      <= dly;
    in_ch.elapsed    <= el;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_request(act, code, pay, dly, el);
    n_req++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  // Sink stalls: stretches of low ready of random length
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(stall_max, 1) - 1;
      end else begin
        out_ch.ready <= 1'b1;
        hold = (stall_pct > 0) ? $urandom_range(5, 0) : 0;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = status_t'(out_ch.status);
      got.code   = out_ch.fired_code;
      got.pay    = out_ch.fired_payload;
      got.last   = out_ch.last;
      n_results++;
      if (got.status == STS_EXPIRED) n_fired++;
      if (got.status == STS_FULL) n_full++;
      if (due_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("[%0t] unexpected result beat: st=%0d code=%02h pay=%02h last=%0b",
                   $realtime, got.status, got.code, got.pay, got.last);
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status || got.code !== want.code ||
            got.pay !== want.pay || got.last !== want.last) begin
          err_count++;
          if (err_count <= MAX_SHOWN) begin
            $display("[%0t] mismatch: want st=%0d code=%02h pay=%02h last=%0b",
                     $realtime, want.status, want.code, want.pay, want.last);
            $display("           got  st=%0d code=%02h pay=%02h last=%0b",
                     got.status, got.code, got.pay, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    gap_max   = 0;
    stall_pct = 0;
    send_req(ACT_ADD,    8'h00, 8'h12, 16'h0005, 8'h00);
    send_req(ACT_CANCEL, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_UNUSED, 8'h05, 8'h34, 16'h0007, 8'h03);
    send_req(ACT_TICK,   8'h00, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_CANCEL, 8'h55, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_ADD,    8'hFF, 8'h00, 16'hFFFF, 8'h00);
    send_req(ACT_ADD,    8'h01, 8'hFF, 16'h0000, 8'h00);
    send_req(ACT_ADD,    8'h80, 8'h5A, 16'h0001, 8'h00);
    send_req(ACT_ADD,    8'h7F, 8'hA5, 16'h00FF, 8'h00);
    send_req(ACT_ADD,    8'h40, 8'h3C, 16'h0100, 8'h00);
    send_req(ACT_ADD,    8'h20, 8'hC3, 16'h0002, 8'h00);
    send_req(ACT_ADD,    8'h10, 8'h11, 16'h0000, 8'h00);
    send_req(ACT_ADD,    8'h08, 8'h22, 16'h8000, 8'h00);
    // Table full: a new code is refused, a known code still updates
    send_req(ACT_ADD,    8'h42, 8'h77, 16'h0003, 8'h00);
    send_req(ACT_ADD,    8'h80, 8'h99, 16'h0000, 8'h00);
    // Zero delays fire even when no time has passed
    send_req(ACT_TICK,   8'h00, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_CANCEL, 8'h40, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_CANCEL, 8'h40, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_TICK,   8'h00, 8'h00, 16'h0000, 8'hFF);
    send_req(ACT_TICK,   8'h00, 8'h00, 16'h0000, 8'hFF);
    send_req(ACT_CANCEL, 8'hFF, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_CANCEL, 8'h08, 8'h00, 16'h0000, 8'h00);
    send_req(ACT_TICK,   8'h00, 8'h00, 16'h0000, 8'h00);
  endtask

  // Fill the table, get refused, then expire everything in one or two ticks
  task automatic test_fill_and_expire();
    int base;
    gap_max   = 3;
    burst_max = 6;
    stall_pct = 30;
    stall_max = 4;
    repeat (5) begin
      base = $urandom_range(247, 1);
      for (int i = 0; i < TEQ_DEPTH; i++)
        send_req(ACT_ADD, CODE_W'(base + i), PAYLOAD_W'($urandom),
                 DELAY_W'($urandom_range(3, 0)), ELAPSED_W'($urandom));
      send_req(ACT_ADD, CODE_W'(base + TEQ_DEPTH), PAYLOAD_W'($urandom),
               DELAY_W'($urandom), ELAPSED_W'($urandom));
      send_req(ACT_TICK, CODE_W'($urandom), PAYLOAD_W'($urandom),
               DELAY_W'($urandom), ELAPSED_W'($urandom_range(3, 0)));
      send_req(ACT_TICK, CODE_W'($urandom), PAYLOAD_W'($urandom),
               DELAY_W'($urandom), 8'hFF);
    end
  endtask

  // Mostly adds, cancels and ticks on a small pool of codes; a few odd beats
  task automatic run_random(input int n_items, input int code_pool);
    action_t              act;
    logic [CODE_W-1:0]    code;
    logic [PAYLOAD_W-1:0] pay;
    logic [DELAY_W-1:0]   dly;
    logic [ELAPSED_W-1:0] el;
    int                   r;
    repeat (n_items) begin
      r    = $urandom_range(99, 0);
      code = ($urandom_range(9, 0) == 0) ? CODE_W'($urandom)
                                          : CODE_W'($urandom_range(code_pool, 1));
      pay  = PAYLOAD_W'($urandom);
      dly  = ($urandom_range(7, 0) == 0) ? DELAY_W'($urandom)
                                          : DELAY_W'($urandom_range(24, 0));
      el   = ($urandom_range(9, 0) == 0) ? ELAPSED_W'($urandom)
                                          : ELAPSED_W'($urandom_range(8, 0));
      if (r < 45)      act = ACT_ADD;
      else if (r < 65) act = ACT_CANCEL;
      else if (r < 94) act = ACT_TICK;
      else if (r < 97) act = ACT_UNUSED;
      else begin
        act  = ($urandom_range(1, 0) == 0) ? ACT_ADD : ACT_CANCEL;
        code = '0;
      end
      send_req(act, code, pay, dly, el);
    end
  endtask

  task automatic test_random_steady();
    gap_max   = 0;
    stall_pct = 0;
    run_random(80, 10);
  endtask

  task automatic test_random_bursty();
    gap_max   = 5;
    burst_max = 8;
    stall_pct = 25;
    stall_max = 3;
    run_random(82, 12);
  endtask

  task automatic test_random_backpressure();
    gap_max   = 2;
    burst_max = 4;
    stall_pct = 60;
    stall_max = 8;
    run_random(80, 20);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_ADD;
    in_ch.event_code = '0;
    in_ch.payload    = '0;
    in_ch.delay      = '0;
    in_ch.elapsed    = '0;
    for (int i = 0; i < TEQ_DEPTH; i++) begin
      tbl_code[i] = '0;
      tbl_pay[i]  = '0;
      tbl_dly[i]  = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_and_expire();
    test_random_steady();
    test_random_bursty();
    test_random_backpressure();

    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // Let any stray beat show up before the final check
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) begin
      err_count += due_results.size();
      $display("%0d predicted results never arrived", due_results.size());
    end

    $display("Sent %0d requests, checked %0d result beats", n_req, n_results);
    $display("Saw %0d expirations and %0d full-table refusals, %0d errors",
             n_fired, n_full, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/teq_pkg.sv
rtl/core/teq_in_if.sv
rtl/core/teq_out_if.sv
rtl/core/teq_ctrl.sv
rtl/core/teq_dpath.sv
rtl/core/timed_event_queue_core.sv
tb/timed_event_queue_core_tb.sv
